[rtl/core/rfpd_pkg.sv]
// Shared types, constants and codes for the range/flow packet decoder.
package rfpd_pkg;

    localparam int TIMEOUT_MS_DEF   = 200;
    localparam int MAX_RANGE_CM_DEF = 1200;
    localparam int FLOW_FRAC_BITS   = 24;

    localparam logic [7:0]  HDR_FIRST       = 8'hAA;
    localparam logic [7:0]  HDR_SECOND      = 8'h55;
    localparam int          PAYLOAD_LEN     = 11;
    localparam logic [15:0] MIN_FLOW_RAW_CM = 16'd10;
    localparam logic [19:0] US_PER_UNIT     = 20'd1000000;
    // floor(2^30 / 100), used for the divide by 100 of the scaled distance
    localparam logic [23:0] RECIP_100       = 24'd10737418;
    localparam logic [6:0]  PCT_DIV         = 7'd100;

    localparam int DIST_W = 19;
    localparam int FLOW_W = 26;
    localparam int CNT_W  = 32;
    localparam int DEN_W  = 36;
    localparam int DIVC_W = $clog2(FLOW_FRAC_BITS);

    typedef enum logic [1:0] {
        EV_GOOD    = 2'd0,
        EV_BAD     = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        REG_RANGE_SCALE = 3'd0,
        REG_FLOW_SCALE  = 3'd1,
        REG_MIN_ALT     = 3'd2,
        REG_MAX_ALT     = 3'd3,
        REG_INVERT_X    = 3'd4,
        REG_INVERT_Y    = 3'd5,
        REG_ALIGN       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_HDR1,
        PH_HDR2,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RECIP,
        ST_FIX,
        ST_JUDGE,
        ST_DIV,
        ST_ROT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic check;
        logic recip;
        logic fix;
        logic judge;
        logic div_step;
        logic rot;
    } cmd_t;

    typedef struct packed {
        logic pkt_end;
        logic tmo_fire;
        logic bad;
        logic flow_en;
        logic div_last;
    } status_t;

endpackage

[rtl/core/range_flow_packet_decoder.sv]
// Range/flow link packet decoder: top level.
// Input stream s_*: one beat is either a link byte (s_tuser = 0, byte in
// s_tdata) or a one-millisecond tick (s_tuser = 1). Bytes are framed by the
// header AA 55 and 11 payload bytes; the closing byte of a packet, or a tick
// that exceeds the silence limit, produces one result beat on m_*.
// Other beats produce nothing and leave the block ready for the next beat.
// Path to m_tvalid: checksum failure via CHECK; good packet without flow via
// CHECK, RECIP, FIX and JUDGE; good packet with flow also via DIV, the 24-step
// shift-subtract divider for both flow axes in parallel, and ROT; timeout direct.
// One beat is in flight at a time: s_tready is low from the closing byte (or
// timeout tick) until the result beat has been taken.
// The result is held in registers while m_tready is low; the block waits.
// Config channel: cfg_valid/cfg_ready, register index and data; always
// ready and applied at once, so writes belong only where no beat is in flight.
// Reset (rst_n low, async) restores register defaults, clears counters and
// parser, and leaves the output channel empty.
module range_flow_packet_decoder #(
    parameter int TIMEOUT_MS   = rfpd_pkg::TIMEOUT_MS_DEF,
    parameter int MAX_RANGE_CM = rfpd_pkg::MAX_RANGE_CM_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] operation
    output logic         m_tvalid,
    input  logic         m_tready,
    // [18:0] distance_cm, [19] distance_ok, [45:20] flow_x, [71:46] flow_y,
    // [72] flow_ok, [104:73] good_total, [136:105] bad_total, [143:137] zero
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] event_res
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import rfpd_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic signed [DIST_W-1:0] distance_cm;
    logic                     distance_ok;
    logic signed [FLOW_W-1:0] flow_x, flow_y;
    logic                     flow_ok;
    logic [CNT_W-1:0]         good_total, bad_total;

    assign cfg_ready = 1'b1;

    rfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    rfpd_datapath #(
        .TIMEOUT_MS   (TIMEOUT_MS),
        .MAX_RANGE_CM (MAX_RANGE_CM)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_byte     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .event_res   (m_tuser),
        .distance_cm (distance_cm),
        .distance_ok (distance_ok),
        .flow_x      (flow_x),
        .flow_y      (flow_y),
        .flow_ok     (flow_ok),
        .good_total  (good_total),
        .bad_total   (bad_total)
    );

    assign m_tdata = {7'd0, bad_total, good_total, flow_ok, flow_y, flow_x,
                      distance_ok, distance_cm};

endmodule

[rtl/core/rfpd_ctrl.sv]
// Sequencer for the packet decoder: accept, check, scale, divide, emit.
module rfpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              m_tready,
    input  rfpd_pkg::status_t status,
    output rfpd_pkg::cmd_t    cmd,
    output logic              s_tready,
    output logic              m_tvalid
);
    import rfpd_pkg::*;

    state_t state_reg, state_next;
    logic   fire;

    assign fire = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire && status.pkt_end)
                    state_next = ST_CHECK;
                else if (fire && status.tmo_fire)
                    state_next = ST_OUT;
            end
            ST_CHECK:  state_next = status.bad ? ST_OUT : ST_RECIP;
            ST_RECIP:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_JUDGE;
            ST_JUDGE:  state_next = status.flow_en ? ST_DIV : ST_OUT;
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_ROT;
            end
            ST_ROT:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = fire;
        cmd.check    = (state_reg == ST_CHECK);
        cmd.recip    = (state_reg == ST_RECIP);
        cmd.fix      = (state_reg == ST_FIX);
        cmd.judge    = (state_reg == ST_JUDGE);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.rot      = (state_reg == ST_ROT);
        s_tready     = (state_reg == ST_IDLE);
        m_tvalid     = (state_reg == ST_OUT);
    end

endmodule

[rtl/core/rfpd_datapath.sv]
// Parser, payload store, counters, scaling and flow divider datapath.
module rfpd_datapath #(
    parameter int TIMEOUT_MS   = rfpd_pkg::TIMEOUT_MS_DEF,
    parameter int MAX_RANGE_CM = rfpd_pkg::MAX_RANGE_CM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rfpd_pkg::cmd_t                    cmd,
    output rfpd_pkg::status_t                 status,
    input  logic                              in_op,
    input  logic [7:0]                        in_byte,
    input  logic                              cfg_valid,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    output logic [1:0]                        event_res,
    output logic signed [rfpd_pkg::DIST_W-1:0] distance_cm,
    output logic                              distance_ok,
    output logic signed [rfpd_pkg::FLOW_W-1:0] flow_x,
    output logic signed [rfpd_pkg::FLOW_W-1:0] flow_y,
    output logic                              flow_ok,
    output logic [rfpd_pkg::CNT_W-1:0]        good_total,
    output logic [rfpd_pkg::CNT_W-1:0]        bad_total
);
    import rfpd_pkg::*;

    localparam int QW = FLOW_FRAC_BITS;

    // configuration
    logic [7:0]  rscale_reg, fscale_reg;
    logic [15:0] min_alt_reg, max_alt_reg;
    logic        inv_x_reg, inv_y_reg;
    logic [1:0]  align_reg;

    // parser and counters
    phase_t      phase_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  pay_reg [PAYLOAD_LEN];
    logic [7:0]  idle_reg;
    logic        tmo_reg;
    logic [CNT_W-1:0] good_reg, bad_reg;

    // arithmetic
    logic [23:0]      p_reg;
    logic [47:0]      pk_reg;
    logic [17:0]      dist_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_x_reg, rem_y_reg;
    logic [QW-1:0]    q_x_reg, q_y_reg;
    logic             neg_x_reg, neg_y_reg;
    logic [DIVC_W-1:0] divc_reg;

    // result
    logic [1:0]              ev_reg;
    logic signed [DIST_W-1:0] rdist_reg;
    logic                    rdok_reg;
    logic signed [FLOW_W-1:0] rfx_reg, rfy_reg;
    logic                    rfok_reg;

    logic [7:0]  csum;
    logic [15:0] raw;
    logic signed [15:0] vx, vy;
    logic [16:0] mag_x, mag_y;
    logic [17:0] q0;
    logic [23:0] resid;
    logic        dok;
    logic        alt_zero;
    logic [DEN_W:0] sh_x, sh_y;
    logic        ge_x, ge_y;
    logic signed [FLOW_W-1:0] ax, ay, fx, fy;

    always_comb
    begin
        csum = '0;
        for (int i = 0; i < PAYLOAD_LEN - 1; i++)
            csum = csum ^ pay_reg[i];
    end

    assign raw   = {pay_reg[9], pay_reg[8]};
    assign vx    = {pay_reg[5], pay_reg[4]};
    assign vy    = {pay_reg[7], pay_reg[6]};
    assign mag_x = vx[15] ? (17'd0 - {vx[15], vx}) : {1'b0, vx};
    assign mag_y = vy[15] ? (17'd0 - {vy[15], vy}) : {1'b0, vy};

    assign q0    = pk_reg[47:30];
    assign resid = p_reg - 24'(q0 * PCT_DIV);

    assign dok = (dist_reg != '0) && ({14'd0, dist_reg} < 32'(MAX_RANGE_CM));
    assign alt_zero = ((min_alt_reg != '0) && (raw < min_alt_reg))
                   || ((max_alt_reg != '0) && (raw > max_alt_reg));

    assign sh_x = {rem_x_reg, 1'b0};
    assign sh_y = {rem_y_reg, 1'b0};
    assign ge_x = sh_x >= {1'b0, den_reg};
    assign ge_y = sh_y >= {1'b0, den_reg};

    always_comb
    begin
        ax = neg_x_reg ? -$signed({2'b00, q_x_reg}) : $signed({2'b00, q_x_reg});
        ay = neg_y_reg ? -$signed({2'b00, q_y_reg}) : $signed({2'b00, q_y_reg});
        if (inv_x_reg)
            ax = -ax;
        if (inv_y_reg)
            ay = -ay;
        case (align_reg)
            2'd1:
            begin
                fx = -ay;
                fy = ax;
            end
            2'd2:
            begin
                fx = -ax;
                fy = -ay;
            end
            2'd3:
            begin
                fx = ay;
                fy = -ax;
            end
            default:
            begin
                fx = ax;
                fy = ay;
            end
        endcase
    end

    always_comb
    begin
        status          = '0;
        status.pkt_end  = !in_op && (phase_reg == PH_PAYLOAD)
                       && (idx_reg == 4'(PAYLOAD_LEN - 1));
        status.tmo_fire = in_op && (idle_reg == 8'(TIMEOUT_MS)) && !tmo_reg;
        status.bad      = (csum != pay_reg[PAYLOAD_LEN-1]);
        status.flow_en  = dok && (raw > MIN_FLOW_RAW_CM) && !alt_zero;
        status.div_last = (divc_reg == DIVC_W'(QW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rscale_reg  <= 8'd100;
            fscale_reg  <= 8'd100;
            min_alt_reg <= '0;
            max_alt_reg <= '0;
            inv_x_reg   <= 1'b0;
            inv_y_reg   <= 1'b0;
            align_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RANGE_SCALE: rscale_reg  <= cfg_data[7:0];
                REG_FLOW_SCALE:  fscale_reg  <= cfg_data[7:0];
                REG_MIN_ALT:     min_alt_reg <= cfg_data;
                REG_MAX_ALT:     max_alt_reg <= cfg_data;
                REG_INVERT_X:    inv_x_reg   <= cfg_data[0];
                REG_INVERT_Y:    inv_y_reg   <= cfg_data[0];
                REG_ALIGN:       align_reg   <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            idx_reg   <= '0;
            idle_reg  <= '0;
            tmo_reg   <= 1'b0;
            good_reg  <= '0;
            bad_reg   <= '0;
            divc_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (in_op)
                begin
                    if (idle_reg < 8'(TIMEOUT_MS))
                        idle_reg <= idle_reg + 8'd1;
                    else
                        tmo_reg <= 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_HDR2:
                        begin
                            phase_reg <= (in_byte == HDR_SECOND) ? PH_PAYLOAD : PH_HDR1;
                            idx_reg   <= '0;
                        end
                        PH_PAYLOAD:
                        begin
                            if (status.pkt_end)
                            begin
                                phase_reg <= PH_HDR1;
                                idx_reg   <= '0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 4'd1;
                            end
                        end
                        default:
                        begin
                            phase_reg <= (in_byte == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
                        end
                    endcase
                end
            end
            if (cmd.check)
            begin
                if (status.bad)
                begin
                    bad_reg <= bad_reg + 1'b1;
                end
                else
                begin
                    good_reg <= good_reg + 1'b1;
                    idle_reg <= '0;
                    tmo_reg  <= 1'b0;
                end
            end
            if (cmd.judge)
                divc_reg <= '0;
            else if (cmd.div_step)
                divc_reg <= divc_reg + 1'b1;
        end
    end

    // payload and arithmetic registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !in_op && (phase_reg == PH_PAYLOAD))
            pay_reg[idx_reg] <= in_byte;

        if (cmd.accept && status.tmo_fire)
        begin
            ev_reg    <= EV_TIMEOUT;
            rdist_reg <= '1;
            rdok_reg  <= 1'b0;
            rfx_reg   <= '0;
            rfy_reg   <= '0;
            rfok_reg  <= 1'b0;
        end

        if (cmd.check)
        begin
            p_reg     <= 24'(raw * rscale_reg);
            den_reg   <= DEN_W'(raw * US_PER_UNIT);
            rem_x_reg <= DEN_W'(mag_x * fscale_reg);
            rem_y_reg <= DEN_W'(mag_y * fscale_reg);
            neg_x_reg <= vx[15];
            neg_y_reg <= vy[15];
            ev_reg    <= status.bad ? EV_BAD : EV_GOOD;
            rdist_reg <= '0;
            rdok_reg  <= 1'b0;
            rfx_reg   <= '0;
            rfy_reg   <= '0;
            rfok_reg  <= 1'b0;
        end

        if (cmd.recip)
            pk_reg <= p_reg * RECIP_100;

        if (cmd.fix)
            dist_reg <= (resid >= 24'(PCT_DIV)) ? q0 + 18'd1 : q0;

        if (cmd.judge)
        begin
            rdist_reg <= $signed({1'b0, dist_reg});
            rdok_reg  <= dok;
        end

        if (cmd.div_step)
        begin
            rem_x_reg <= ge_x ? DEN_W'(sh_x - {1'b0, den_reg}) : sh_x[DEN_W-1:0];
            rem_y_reg <= ge_y ? DEN_W'(sh_y - {1'b0, den_reg}) : sh_y[DEN_W-1:0];
            q_x_reg   <= {q_x_reg[QW-2:0], ge_x};
            q_y_reg   <= {q_y_reg[QW-2:0], ge_y};
        end

        if (cmd.rot)
        begin
            rfx_reg  <= fx;
            rfy_reg  <= fy;
            rfok_reg <= rdok_reg && ((fx != '0) || (fy != '0));
        end
    end

    assign event_res   = ev_reg;
    assign distance_cm = rdist_reg;
    assign distance_ok = rdok_reg;
    assign flow_x      = rfx_reg;
    assign flow_y      = rfy_reg;
    assign flow_ok     = rfok_reg;
    assign good_total  = good_reg;
    assign bad_total   = bad_reg;

endmodule
